// File: sv/assert_macros.svh
// Assertion helper macros for the packer RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// expression must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/lbfo_pkg.sv
// Package for the best-fit offset packer: widths, cell structs, candidate compare.
// No dependencies.
`timescale 1ns / 1ps
package lbfo_pkg;
    localparam int MAX_ENTRIES = 256;
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = 16;
    localparam int SW = 32;
    localparam int OW = 40;
    localparam int EW = 41;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic load;
        logic rot;
        logic sel;
        logic red;
        logic wr;
    } t_cell_ctl;

    // entry circulating round the ring
    typedef struct packed {
        logic          act;
        logic [OW-1:0] lo;
        logic [EW-1:0] hi;
    } t_strm;

    // gap candidate moving down the chain
    typedef struct packed {
        logic          ok;
        logic [EW-1:0] waste;
        logic [EW-1:0] off;
    } t_cand;

    // least waste wins, then lowest offset
    function automatic t_cand cand_better(input t_cand a, input t_cand b);
        t_cand r;
        if (a.ok && (!b.ok || a.waste < b.waste || (a.waste == b.waste && a.off <= b.off)))
            r = a;
        else
            r = b;
        return r;
    endfunction
endpackage

// File: sv/lbfo_if.sv
// Valid/ready channel interfaces for buffer requests and placements.
// Depends on lbfo_pkg for field widths.
`timescale 1ns / 1ps
interface lbfo_in_if;
    import lbfo_pkg::*;
    logic          valid;
    logic          ready;
    logic          first_of_set;
    logic [TW-1:0] birth_step;
    logic [TW-1:0] death_step;
    logic [SW-1:0] alloc_size;
    modport source (output valid, first_of_set, birth_step, death_step, alloc_size,
                    input ready);
    modport sink (input valid, first_of_set, birth_step, death_step, alloc_size,
                  output ready);
endinterface

interface lbfo_out_if;
    import lbfo_pkg::*;
    logic          valid;
    logic          ready;
    logic [OW-1:0] placed_offset;
    logic [EW-1:0] peak_so_far;
    logic          table_full;
    modport source (output valid, placed_offset, peak_so_far, table_full, input ready);
    modport sink (input valid, placed_offset, peak_so_far, table_full, output ready);
endinterface

// File: sv/lifetime_best_fit_offset_packer.sv
// Each placed buffer takes one full turn of the entry ring after the load,
// then the select step and one pass of the best-gap reduction chain,
// then saturation and write; a full-table item skips straight to its result.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) clears entry count, peak and handshake state;
// the cell contents are not cleared and are only read below the entry count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lifetime_best_fit_offset_packer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbfo_in_if.sink    i_in,
    lbfo_out_if.source o_out
);
    import lbfo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROT, S_SEL, S_RED, S_FIN, S_WR, S_FULL
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_cnt;
    logic [CW-1:0] r_count;
    logic [EW-1:0] r_peak;
    logic [TW-1:0] r_birth, r_death;
    logic [SW-1:0] r_size;
    logic          r_any;
    logic [OW-1:0] r_min_lo, r_off;
    logic [EW-1:0] r_max_hi;
    logic          r_o_valid, r_o_full;
    logic [OW-1:0] r_o_off;
    logic [EW-1:0] r_o_peak;

    t_cell_ctl     w_ctl;
    t_strm         w_strm [MAX_ENTRIES];
    t_cand         w_red  [MAX_ENTRIES];
    t_cand         w_cand0, w_best;
    logic [EW-1:0] w_off_raw, w_end;
    logic          w_out_free, w_acc;
    logic [CW-1:0] w_count0;

    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_count0   = i_in.first_of_set ? '0 : r_count;

    // cell control
    assign w_ctl.load = (r_state == S_LOAD);
    assign w_ctl.rot  = (r_state == S_ROT);
    assign w_ctl.sel  = (r_state == S_SEL);
    assign w_ctl.red  = (r_state == S_RED);
    assign w_ctl.wr   = (r_state == S_WR) && w_out_free;

    // chain of cells: stream rings round, candidates move toward cell 0
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lbfo_cell u_cell (
            .i_clk      (i_clk),
            .i_idx      (IW'(g)),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_birth    (r_birth),
            .i_death    (r_death),
            .i_size     (r_size),
            .i_wr_idx   (r_count[IW-1:0]),
            .i_wr_start (r_off),
            .i_wr_end   (w_end),
            .i_strm_nb  (w_strm[(g + 1) % MAX_ENTRIES]),
            .o_strm     (w_strm[g]),
            .i_red_nb   ((g == MAX_ENTRIES - 1) ? t_cand'('0) : w_red[(g + 1) % MAX_ENTRIES]),
            .o_red      (w_red[g])
        );
    end

    // gap below the lowest interval against the chain's best gap
    assign w_cand0.ok    = r_any && ({1'b0, r_min_lo} >= {{(EW-SW){1'b0}}, r_size});
    assign w_cand0.waste = {1'b0, r_min_lo} - {{(EW-SW){1'b0}}, r_size};
    assign w_cand0.off   = '0;
    assign w_best        = cand_better(w_cand0, w_red[0]);
    assign w_off_raw     = w_best.ok ? w_best.off : (r_any ? r_max_hi : '0);
    assign w_end         = {1'b0, r_off} + {{(EW-SW){1'b0}}, r_size};

    // sequencer, table bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_peak    <= '0;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (r_o_valid && o_out.ready)
                r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_birth <= i_in.birth_step;
                        r_death <= i_in.death_step;
                        r_size  <= i_in.alloc_size;
                        r_count <= w_count0;
                        if (i_in.first_of_set)
                            r_peak <= '0;
                        r_state <= (w_count0 >= CW'(MAX_ENTRIES)) ? S_FULL : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_any    <= 1'b0;
                    r_min_lo <= '1;
                    r_max_hi <= '0;
                    r_cnt    <= '0;
                    r_state  <= S_ROT;
                end
                S_ROT: begin
                    // every entry passes cell 0 once per turn
                    if (w_strm[0].act) begin
                        r_any <= 1'b1;
                        if (w_strm[0].lo < r_min_lo)
                            r_min_lo <= w_strm[0].lo;
                        if (w_strm[0].hi > r_max_hi)
                            r_max_hi <= w_strm[0].hi;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(MAX_ENTRIES - 1))
                        r_state <= S_SEL;
                end
                S_SEL: begin
                    r_cnt   <= '0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(MAX_ENTRIES - 1))
                        r_state <= S_FIN;
                end
                S_FIN: begin
                    // saturate to the offset range
                    r_off   <= w_off_raw[EW-1] ? '1 : w_off_raw[OW-1:0];
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (w_out_free) begin
                        r_count   <= r_count + 1'b1;
                        r_o_valid <= 1'b1;
                        r_o_full  <= 1'b0;
                        r_o_off   <= r_off;
                        r_o_peak  <= (w_end > r_peak) ? w_end : r_peak;
                        if (w_end > r_peak)
                            r_peak <= w_end;
                        r_state <= S_IDLE;
                    end
                end
                S_FULL: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_full  <= 1'b1;
                        r_o_off   <= '0;
                        r_o_peak  <= r_peak;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_o_valid;
    assign o_out.placed_offset = r_o_off;
    assign o_out.peak_so_far   = r_o_peak;
    assign o_out.table_full    = r_o_full;

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CW'(MAX_ENTRIES), "entry count overflow")
    `ASSERT_ALWAYS(a_full_zero, i_clk, i_rst_n, !(r_o_valid && r_o_full) || r_o_off == '0, "full result with offset")
    `ASSERT_NEXT(a_peak_mono, i_clk, i_rst_n, !(w_acc && i_in.first_of_set), r_peak >= $past(r_peak), "peak fell within a set")
    `ASSERT_NEXT(a_wr_out, i_clk, i_rst_n, w_ctl.wr, r_o_valid && !r_o_full, "write without placed result")
endmodule

// File: sv/lbfo_cell.sv
// One table cell: holds a placed buffer, checks its end as a gap start against
// the circulating entries, then joins the best-gap reduction. Uses lbfo_pkg.
`timescale 1ns / 1ps
module lbfo_cell (
    input  logic                    i_clk,
    input  logic [lbfo_pkg::IW-1:0] i_idx,
    input  lbfo_pkg::t_cell_ctl     i_ctl,
    input  logic [lbfo_pkg::CW-1:0] i_count,
    input  logic [lbfo_pkg::TW-1:0] i_birth,
    input  logic [lbfo_pkg::TW-1:0] i_death,
    input  logic [lbfo_pkg::SW-1:0] i_size,
    input  logic [lbfo_pkg::IW-1:0] i_wr_idx,
    input  logic [lbfo_pkg::OW-1:0] i_wr_start,
    input  logic [lbfo_pkg::EW-1:0] i_wr_end,
    input  lbfo_pkg::t_strm         i_strm_nb,
    output lbfo_pkg::t_strm         o_strm,
    input  lbfo_pkg::t_cand         i_red_nb,
    output lbfo_pkg::t_cand         o_red
);
    import lbfo_pkg::*;

    logic [TW-1:0] r_birth, r_death;
    logic [OW-1:0] r_start;
    logic [EW-1:0] r_end;
    logic          r_act, r_dq, r_has_nl;
    logic [OW-1:0] r_nl;
    t_strm         r_strm;
    t_cand         r_red;

    logic          w_act;
    logic [EW-1:0] w_gap;
    t_cand         w_own;

    // entry is live in the table and its lifetime overlaps the new buffer
    assign w_act = ({1'b0, i_idx} < i_count) &&
                   !(i_death < r_birth || r_death < i_birth);

    // own candidate gap: from this end to the next interval start above it
    assign w_gap       = {1'b0, r_nl} - r_end;
    assign w_own.ok    = r_act && !r_dq && r_has_nl && (w_gap >= {{(EW-SW){1'b0}}, i_size});
    assign w_own.waste = w_gap - {{(EW-SW){1'b0}}, i_size};
    assign w_own.off   = r_end;

    // entry store
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_wr_idx == i_idx) begin
            r_birth <= i_birth;
            r_death <= i_death;
            r_start <= i_wr_start;
            r_end   <= i_wr_end;
        end
    end

    // ring pass and reduction
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_act    <= w_act;
            r_strm   <= '{act: w_act, lo: r_start, hi: r_end};
            r_dq     <= 1'b0;
            r_has_nl <= 1'b0;
            r_nl     <= '1;
        end else if (i_ctl.rot) begin
            r_strm <= i_strm_nb;
            if (r_strm.act) begin
                // end covered by another interval: not a group end
                if ({1'b0, r_strm.lo} <= r_end && r_end < r_strm.hi)
                    r_dq <= 1'b1;
                // nearest start strictly above this end
                if ({1'b0, r_strm.lo} > r_end && (!r_has_nl || r_strm.lo < r_nl)) begin
                    r_nl     <= r_strm.lo;
                    r_has_nl <= 1'b1;
                end
            end
        end
        if (i_ctl.sel)
            r_red <= w_own;
        else if (i_ctl.red)
            r_red <= cand_better(r_red, i_red_nb);
    end

    assign o_strm = r_strm;
    assign o_red  = r_red;
endmodule
